// ----- sv/skf_pkg.sv -----
// ----------------------------------------------------------------------------
// skf_pkg
// Shared constants, codes and types of the multi-channel scalar Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int SKF_CHANNELS = 4;

  localparam int CH_W    = 2;
  localparam int DATA_W  = 24;
  localparam int FRAC_W  = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [DATA_W-1:0] Q_RESET    = 24'd1678;
  localparam logic [DATA_W-1:0] R_RESET    = 24'd8389;
  localparam logic [DATA_W-1:0] P0_RESET   = 24'd16777;
  localparam logic [DATA_W-1:0] COV_RESET  = 24'd16777;
  localparam logic [DATA_W-1:0] UMAX       = 24'hFFFFFF;
  localparam logic signed [DATA_W-1:0] SMAX = 24'sh7FFFFF;
  localparam logic signed [DATA_W-1:0] SMIN = -24'sh800000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_COVARIANCE = 2'd2;

  // divider runs one quotient bit per step
  localparam int DIV_STEPS = FRAC_W;
  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

  // program counter and microcode fields
  localparam int PC_W = 4;
  localparam int OP_W = 4;
  localparam int COND_W = 3;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [COND_W-1:0] cond_t;
  typedef logic [PC_W-1:0]   pc_t;

  localparam op_t OP_IDLE  = 4'd0;
  localparam op_t OP_PRED  = 4'd1;
  localparam op_t OP_DEN   = 4'd2;
  localparam op_t OP_DIV   = 4'd3;
  localparam op_t OP_GAIN  = 4'd4;
  localparam op_t OP_MULA  = 4'd5;
  localparam op_t OP_UPD   = 4'd6;
  localparam op_t OP_WAIT  = 4'd7;
  localparam op_t OP_WRITE = 4'd8;

  localparam cond_t C_NONE     = 3'd0;
  localparam cond_t C_NO_ITEM  = 3'd1;
  localparam cond_t C_DIV_MORE = 3'd2;
  localparam cond_t C_OUT_BUSY = 3'd3;
  localparam cond_t C_ALWAYS   = 3'd4;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  // datapath conditions seen by the sequencer
  typedef struct packed {
    logic item_in;
    logic div_more;
    logic out_busy;
  } status_t;

endpackage

// ----- sv/skf_if.sv -----
// ----------------------------------------------------------------------------
// skf_sample_if / skf_result_if
// Valid/ready channels carrying measurement items and filtered results.
// ----------------------------------------------------------------------------
interface skf_sample_if;
  logic valid;
  logic ready;
  logic [skf_pkg::CH_W-1:0] channel;
  logic restart;
  logic signed [skf_pkg::DATA_W-1:0] measurement;

  modport source (output valid, channel, restart, measurement, input ready);
  modport sink (input valid, channel, restart, measurement, output ready);
endinterface

interface skf_result_if;
  logic valid;
  logic ready;
  logic [skf_pkg::CH_W-1:0] out_channel;
  logic signed [skf_pkg::DATA_W-1:0] estimate;
  logic [skf_pkg::DATA_W-1:0] gain;

  modport source (output valid, out_channel, estimate, gain, input ready);
  modport sink (input valid, out_channel, estimate, gain, output ready);
endinterface

// ----- sv/skf_sequencer.sv -----
// ----------------------------------------------------------------------------
// skf_sequencer
// Step counter over a read-only microprogram, with conditional jumps.
// ----------------------------------------------------------------------------
module skf_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  skf_pkg::status_t  status,
  output skf_pkg::op_t      op
);
  import skf_pkg::*;

  pc_t    pc;
  pc_t    pc_next;
  ucode_t word;
  logic   jump;

  function automatic ucode_t rom(input pc_t addr);
    ucode_t w;
    case (addr)
      4'd0:    w = '{op: OP_IDLE,  cond: C_NO_ITEM,  target: 4'd0};
      4'd1:    w = '{op: OP_PRED,  cond: C_NONE,     target: 4'd0};
      4'd2:    w = '{op: OP_DEN,   cond: C_NONE,     target: 4'd0};
      4'd3:    w = '{op: OP_DIV,   cond: C_DIV_MORE, target: 4'd3};
      4'd4:    w = '{op: OP_GAIN,  cond: C_NONE,     target: 4'd0};
      4'd5:    w = '{op: OP_MULA,  cond: C_NONE,     target: 4'd0};
      4'd6:    w = '{op: OP_UPD,   cond: C_NONE,     target: 4'd0};
      4'd7:    w = '{op: OP_WAIT,  cond: C_OUT_BUSY, target: 4'd7};
      4'd8:    w = '{op: OP_WRITE, cond: C_ALWAYS,   target: 4'd0};
      default: w = '{op: OP_IDLE,  cond: C_ALWAYS,   target: 4'd0};
    endcase
    return w;
  endfunction

  assign word = rom(pc);
  assign op   = word.op;

  always_comb begin
    case (word.cond)
      C_NO_ITEM:  jump = !status.item_in;
      C_DIV_MORE: jump = status.div_more;
      C_OUT_BUSY: jump = status.out_busy;
      C_ALWAYS:   jump = 1'b1;
      default:    jump = 1'b0;
    endcase
    pc_next = jump ? word.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ----- sv/scalar_kalman_filter_unit.sv -----
// ----------------------------------------------------------------------------
// scalar_kalman_filter_unit
// Multi-channel one-dimensional Kalman filter, microcoded datapath.
// ----------------------------------------------------------------------------
// usage:
//   sample carries channel, restart and a signed Q15.8 measurement; result
//   returns out_channel, the new Q15.8 estimate and the Q0.24 gain used.
//   cfg_we/cfg_index/cfg_data write Q, R and the restart covariance; write
//   them only while no item is in flight.
// timing:
//   one item at a time; sample.ready is high only when the sequencer sits
//   at its idle step. an item occupies the unit from acceptance to the next
//   possible acceptance: the prediction, the 24-step restoring divider (one
//   quotient bit per cycle), the gain, two shared-multiplier passes, the
//   wait step and the state write-back, which also loads the result register.
// reset:
//   rst (synchronous) clears the per-channel valid bits, so every channel
//   reads as estimate 0 and covariance 16777; registers take their defaults.
// stall:
//   the result waits in an output register; a later item is held in the
//   wait step only if the previous result has not been taken yet.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_unit #(
  parameter int CHANNELS = skf_pkg::SKF_CHANNELS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [skf_pkg::DATA_W-1:0]     cfg_data,
  skf_sample_if.sink                     sample,
  skf_result_if.source                   result
);
  import skf_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RED_W = 7;
  localparam logic [RED_W-1:0] CH_RED = RED_W'(CHANNELS);
  localparam logic [DATA_W:0] ONE_Q = 25'h1000000;

  // configuration
  logic [DATA_W-1:0] q_noise;
  logic [DATA_W-1:0] r_noise;
  logic [DATA_W-1:0] p_init;

  // channel state
  logic [2*DATA_W-1:0] mem [CHANNELS];
  logic [CHANNELS-1:0] vld;
  logic [2*DATA_W-1:0] rd_word;
  logic                rd_valid;

  // item registers
  logic [IDX_W-1:0]         idx;
  logic [CH_W-1:0]          ch;
  logic                     restart;
  logic signed [DATA_W-1:0] meas;

  // datapath
  logic signed [DATA_W-1:0] est;
  logic [DATA_W-1:0]        pred;
  logic [DATA_W:0]          den;
  logic [DATA_W+1:0]        rem;
  logic [DATA_W-1:0]        quo;
  logic [CNT_W-1:0]         cnt;
  logic [DATA_W-1:0]        gain;
  logic signed [DATA_W:0]   diff;
  logic signed [50:0]       prod;
  logic signed [DATA_W-1:0] est_new;

  // output register
  logic                     out_valid;
  logic [CH_W-1:0]          out_ch;
  logic signed [DATA_W-1:0] out_est;
  logic [DATA_W-1:0]        out_gain;

  op_t     op;
  status_t status;
  logic    item_in;

  logic [RED_W-1:0]         red;
  logic [IDX_W-1:0]         idx_in;
  logic signed [DATA_W-1:0] base_est;
  logic [DATA_W-1:0]        base_cov;
  logic [DATA_W:0]          pred_sum;
  logic [DATA_W+1:0]        shifted;
  logic signed [25:0]       mul_a;
  logic signed [24:0]       mul_b;
  logic signed [50:0]       mul_p;
  logic signed [26:0]       upd_sum;

  assign sample.ready = (op == OP_IDLE) && !rst;
  assign item_in      = sample.valid && sample.ready;

  assign status.item_in  = item_in;
  assign status.div_more = (cnt != DIV_LAST);
  assign status.out_busy = out_valid && !result.ready;

  skf_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  // channel number folded onto the state depth
  always_comb begin
    red = {{(RED_W-CH_W){1'b0}}, sample.channel};
    for (int k = 0; k < 3; k++) begin
      if (red >= CH_RED) begin
        red = red - CH_RED;
      end
    end
    idx_in = red[IDX_W-1:0];
  end

  always_comb begin
    if (restart) begin
      base_est = '0;
      base_cov = p_init;
    end else if (rd_valid) begin
      base_est = rd_word[2*DATA_W-1:DATA_W];
      base_cov = rd_word[DATA_W-1:0];
    end else begin
      base_est = '0;
      base_cov = COV_RESET;
    end
    pred_sum = {1'b0, base_cov} + {1'b0, q_noise};
    shifted  = {rem[DATA_W:0], 1'b0};
  end

  // one shared multiplier: gain * innovation, then (1 - gain) * pred
  always_comb begin
    if (op == OP_UPD) begin
      mul_a = $signed({1'b0, ONE_Q - {1'b0, gain}});
      mul_b = $signed({1'b0, pred});
    end else begin
      mul_a = $signed({2'b00, gain});
      mul_b = diff;
    end
    mul_p   = mul_a * mul_b;
    upd_sum = 27'(est) + prod[50:24];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_noise <= Q_RESET;
      r_noise <= R_RESET;
      p_init  <= P0_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROCESS_NOISE:      q_noise <= cfg_data;
        REG_MEASUREMENT_NOISE:  r_noise <= cfg_data;
        REG_INITIAL_COVARIANCE: p_init  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item_in) begin
      rd_word <= mem[idx_in];
    end
    if (op == OP_WRITE) begin
      mem[idx] <= {est_new, prod[47:24]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (item_in) begin
        rd_valid <= vld[idx_in];
      end
      if (op == OP_WRITE) begin
        vld[idx]  <= 1'b1;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_IDLE: begin
        if (item_in) begin
          idx     <= idx_in;
          ch      <= sample.channel;
          restart <= sample.restart;
          meas    <= sample.measurement;
        end
      end
      OP_PRED: begin
        est  <= base_est;
        pred <= pred_sum[DATA_W] ? UMAX : pred_sum[DATA_W-1:0];
      end
      OP_DEN: begin
        den <= {1'b0, pred} + {1'b0, r_noise};
        rem <= {2'b00, pred};
        quo <= '0;
        cnt <= '0;
      end
      OP_DIV: begin
        // restoring step; the remainder never exceeds the divisor
        if (shifted >= {1'b0, den}) begin
          rem <= shifted - {1'b0, den};
          quo <= {quo[DATA_W-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[DATA_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
      end
      OP_GAIN: begin
        // zero divisor only with R = 0 and an empty prediction
        gain <= (den == '0) ? '0 : quo;
        diff <= 25'(meas) - 25'(est);
      end
      OP_MULA: begin
        prod <= mul_p;
      end
      OP_UPD: begin
        if (upd_sum > 27'(SMAX)) begin
          est_new <= SMAX;
        end else if (upd_sum < 27'(SMIN)) begin
          est_new <= SMIN;
        end else begin
          est_new <= upd_sum[DATA_W-1:0];
        end
        prod <= mul_p;
      end
      OP_WRITE: begin
        out_ch   <= ch;
        out_est  <= est_new;
        out_gain <= gain;
      end
      default: ;
    endcase
  end

  assign result.valid       = out_valid;
  assign result.out_channel = out_ch;
  assign result.estimate    = out_est;
  assign result.gain        = out_gain;

endmodule
